/* hw/rtl/ldr_pkg.sv */
package ldr_pkg;

   localparam int MEDIAN_WINDOW   = 5;
   localparam int PWM_RANGE       = 4096;
   localparam int LUX_TABLE_DEPTH = 256;

   localparam int WIN_IDX_W = $clog2(MEDIAN_WINDOW);
   localparam int LUX_IDX_W = $clog2(LUX_TABLE_DEPTH);
   localparam int CNT_W     = 5;

   localparam logic [CNT_W-1:0] SORT_LAST = CNT_W'(MEDIAN_WINDOW - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(24);
   localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(15);

   localparam logic [24:0] DIV_DIVIDEND = 25'd33000000;
   localparam logic [24:0] R_OFFSET     = 25'd10000;
   localparam logic [11:0] VOLT_SCALE   = 12'd3300;
   localparam logic [16:0] LOG_SCALE    = 17'd120722;
   localparam logic signed [23:0] Y_BASE = 24'sd1339366;
   localparam logic [4:0]  NORM_TOP     = 5'd24;

   localparam logic [15:0] PLANT_GAIN_RST     = 16'd256;
   localparam logic [15:0] PROP_GAIN_RST      = 16'd1311;
   localparam logic [15:0] INTEG_GAIN_RST     = 16'd16384;
   localparam logic [15:0] DERIV_GAIN_RST     = 16'd983;
   localparam logic [13:0] INTEGRAL_LIMIT_RST = 14'd10000;

   typedef enum logic [2:0] {
      CSR_PLANT_GAIN     = 3'd0,
      CSR_PROP_GAIN      = 3'd1,
      CSR_INTEG_GAIN     = 3'd2,
      CSR_DERIV_GAIN     = 3'd3,
      CSR_INTEGRAL_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SORT, ST_VMUL, ST_VOLT, ST_DIV, ST_RES, ST_NORM, ST_SQMUL,
      ST_SQUPD, ST_L2MUL, ST_LUX, ST_ERR, ST_PM0, ST_PM1, ST_PM2, ST_PACC,
      ST_PSAT, ST_DMUL, ST_DUTY, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_VOLT, MUL_SQ, MUL_LOG, MUL_P, MUL_I, MUL_D, MUL_DUTY
   } mul_sel_type;

   typedef struct packed {
      logic        sample_wr;
      logic        sort_step;
      logic        sort_odd;
      mul_sel_type mul_sel;
      logic        volt_ld;
      logic        div_step;
      logic        res_ld;
      logic        norm_step;
      logic        sq_upd;
      logic        lux_ld;
      logic        err_ld;
      logic        acc_clr;
      logic        acc_add;
      logic        pid_ld;
      logic        duty_ld;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic last_sample;
      logic volt_zero;
      logic res_small;
      logic norm_top;
      logic out_busy;
   } status_type;

   typedef logic [16:0] lux_table_type [LUX_TABLE_DEPTH];

   function automatic logic [15:0] log2_frac(input logic [16:0] m_init);
      logic [35:0] m;
      logic [15:0] y;
      m = {19'd0, m_init};
      y = '0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 16;
         if (m >= 36'd131072) begin
            m = m >> 1;
            y[15-k] = 1'b1;
         end
      end
      return y;
   endfunction

   function automatic lux_table_type build_lux_table();
      lux_table_type tbl;
      logic [31:0] t;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mid;
      for (int i = 0; i < LUX_TABLE_DEPTH; i++) begin
         t  = 32'((longint'(i) << 16) / LUX_TABLE_DEPTH);
         lo = 32'd65536;
         hi = 32'd131071;
         while (lo < hi) begin
            mid = (lo + hi + 32'd1) >> 1;
            if ({16'd0, log2_frac(mid[16:0])} <= t) begin
               lo = mid;
            end else begin
               hi = mid - 32'd1;
            end
         end
         tbl[i] = lo[16:0];
      end
      return tbl;
   endfunction

   localparam lux_table_type LUX_TABLE = build_lux_table();

endpackage

/* hw/rtl/ldr_if.sv */
interface ldr_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] adc_sample;
   logic [11:0] setpoint_lux;
   modport source (output valid, output adc_sample, output setpoint_lux, input ready);
   modport sink (input valid, input adc_sample, input setpoint_lux, output ready);
endinterface

interface ldr_rsp_if;
   logic               valid;
   logic               ready;
   logic [12:0]        pwm_duty;
   logic [15:0]        measured_lux;
   logic signed [16:0] control_error;
   logic signed [17:0] pid_output;
   logic               integral_clamped;
   logic               sensor_fault;
   modport source (output valid, output pwm_duty, output measured_lux,
                   output control_error, output pid_output, output integral_clamped,
                   output sensor_fault, input ready);
   modport sink (input valid, input pwm_duty, input measured_lux, input control_error,
                 input pid_output, input integral_clamped, input sensor_fault,
                 output ready);
endinterface

/* hw/rtl/ldr_light_pid_controller_top.sv */
// Channel   Port group   Direction  Contents
// input     req_chan     sink       adc_sample, setpoint_lux
// result    rsp_chan     source     pwm_duty, measured_lux, control_error, pid_output,
//                                   integral_clamped, sensor_fault
// config    csr_*        write      csr_wr_en, csr_index, csr_wr_data
//
// An item that does not complete the window is taken while the controller is idle.
// The result of the completing item is built by five sort passes, 25 divider steps, up to
// 24 shift steps and 16 squaring rounds on the shared multiplier. A zero voltage or zero
// resistance skips the remaining conversion steps and goes straight to the control step.
// Input is refused from the completing item until its result is loaded; a result that
// is not yet taken holds the next completed window in its last step.
// Reset is synchronous and restores the register defaults and the controller state.
module ldr_light_pid_controller_top (
   input  logic        clock,
   input  logic        reset,
   ldr_req_if.sink     req_chan,
   ldr_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   ldr_pkg::cmd_type    cmd;
   ldr_pkg::status_type status;

   ldr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ldr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .adc_sample   (req_chan.adc_sample),
      .setpoint_lux (req_chan.setpoint_lux),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .rsp          (rsp_chan)
   );

endmodule

/* hw/rtl/ldr_ctrl.sv */
module ldr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ldr_pkg::status_type status,
   output ldr_pkg::cmd_type    cmd
);

   ldr_pkg::state_type state_ff, state_in;
   logic [ldr_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldr_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ldr_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && status.last_sample) state_in = ldr_pkg::ST_SORT;
         end
         ldr_pkg::ST_SORT: begin
            if (cnt_ff == ldr_pkg::SORT_LAST) state_in = ldr_pkg::ST_VMUL;
            else cnt_in = cnt_ff + 1'b1;
         end
         ldr_pkg::ST_VMUL: state_in = ldr_pkg::ST_VOLT;
         ldr_pkg::ST_VOLT: begin
            cnt_in   = '0;
            state_in = status.volt_zero ? ldr_pkg::ST_ERR : ldr_pkg::ST_DIV;
         end
         ldr_pkg::ST_DIV: begin
            if (cnt_ff == ldr_pkg::DIV_LAST) state_in = ldr_pkg::ST_RES;
            else cnt_in = cnt_ff + 1'b1;
         end
         ldr_pkg::ST_RES: state_in = status.res_small ? ldr_pkg::ST_ERR : ldr_pkg::ST_NORM;
         ldr_pkg::ST_NORM: begin
            cnt_in = '0;
            if (status.norm_top) state_in = ldr_pkg::ST_SQMUL;
         end
         ldr_pkg::ST_SQMUL: state_in = ldr_pkg::ST_SQUPD;
         ldr_pkg::ST_SQUPD: begin
            if (cnt_ff == ldr_pkg::SQ_LAST) begin
               state_in = ldr_pkg::ST_L2MUL;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ldr_pkg::ST_SQMUL;
            end
         end
         ldr_pkg::ST_L2MUL: state_in = ldr_pkg::ST_LUX;
         ldr_pkg::ST_LUX:   state_in = ldr_pkg::ST_ERR;
         ldr_pkg::ST_ERR:   state_in = ldr_pkg::ST_PM0;
         ldr_pkg::ST_PM0:   state_in = ldr_pkg::ST_PM1;
         ldr_pkg::ST_PM1:   state_in = ldr_pkg::ST_PM2;
         ldr_pkg::ST_PM2:   state_in = ldr_pkg::ST_PACC;
         ldr_pkg::ST_PACC:  state_in = ldr_pkg::ST_PSAT;
         ldr_pkg::ST_PSAT:  state_in = ldr_pkg::ST_DMUL;
         ldr_pkg::ST_DMUL:  state_in = ldr_pkg::ST_DUTY;
         ldr_pkg::ST_DUTY:  state_in = ldr_pkg::ST_OUT;
         ldr_pkg::ST_OUT:   if (!status.out_busy) state_in = ldr_pkg::ST_IDLE;
         default:           state_in = ldr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = ldr_pkg::MUL_VOLT;
      req_ready   = 1'b0;
      unique case (state_ff)
         ldr_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.sample_wr = req_valid;
         end
         ldr_pkg::ST_SORT: begin
            cmd.sort_step = 1'b1;
            cmd.sort_odd  = cnt_ff[0];
         end
         ldr_pkg::ST_VMUL:  cmd.mul_sel = ldr_pkg::MUL_VOLT;
         ldr_pkg::ST_VOLT:  cmd.volt_ld = 1'b1;
         ldr_pkg::ST_DIV:   cmd.div_step = 1'b1;
         ldr_pkg::ST_RES:   cmd.res_ld = 1'b1;
         ldr_pkg::ST_NORM:  cmd.norm_step = 1'b1;
         ldr_pkg::ST_SQMUL: cmd.mul_sel = ldr_pkg::MUL_SQ;
         ldr_pkg::ST_SQUPD: cmd.sq_upd = 1'b1;
         ldr_pkg::ST_L2MUL: cmd.mul_sel = ldr_pkg::MUL_LOG;
         ldr_pkg::ST_LUX:   cmd.lux_ld = 1'b1;
         ldr_pkg::ST_ERR: begin
            cmd.err_ld  = 1'b1;
            cmd.acc_clr = 1'b1;
         end
         ldr_pkg::ST_PM0:   cmd.mul_sel = ldr_pkg::MUL_P;
         ldr_pkg::ST_PM1: begin
            cmd.mul_sel = ldr_pkg::MUL_I;
            cmd.acc_add = 1'b1;
         end
         ldr_pkg::ST_PM2: begin
            cmd.mul_sel = ldr_pkg::MUL_D;
            cmd.acc_add = 1'b1;
         end
         ldr_pkg::ST_PACC:  cmd.acc_add = 1'b1;
         ldr_pkg::ST_PSAT:  cmd.pid_ld = 1'b1;
         ldr_pkg::ST_DMUL:  cmd.mul_sel = ldr_pkg::MUL_DUTY;
         ldr_pkg::ST_DUTY:  cmd.duty_ld = 1'b1;
         ldr_pkg::ST_OUT:   cmd.out_load = !status.out_busy;
         default: begin
         end
      endcase
   end

   sort_then_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ldr_pkg::ST_SORT && cnt_ff == ldr_pkg::SORT_LAST)
      |=> state_ff == ldr_pkg::ST_VMUL)
      else $error("sort pass count overran");
   ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.sort_step && !cmd.out_load)
      else $error("input taken while busy");
   out_leaves: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == ldr_pkg::ST_IDLE)
      else $error("result load did not end the window");

endmodule

/* hw/rtl/ldr_datapath.sv */
module ldr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ldr_pkg::cmd_type    cmd,
   output ldr_pkg::status_type status,
   input  logic [11:0]         adc_sample,
   input  logic [11:0]         setpoint_lux,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wr_data,
   ldr_rsp_if.source           rsp
);

   localparam int N = ldr_pkg::MEDIAN_WINDOW;

   logic [15:0] plant_gain_ff, prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [13:0] integral_limit_ff;

   logic [11:0] win_ff [N];
   logic [11:0] win_in [N];
   logic [ldr_pkg::WIN_IDX_W-1:0] count_ff;
   logic [11:0] setpoint_ff;
   logic [11:0] median;

   logic signed [21:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [39:0] prod_ff, prod_in;

   logic [11:0] volt_ff, rem_ff;
   logic [24:0] dvd_ff, quo_ff, norm_ff;
   logic [12:0] div_t;
   logic        div_ge;
   logic [4:0]  e_ff;
   logic [16:0] m_ff;
   logic [15:0] frac_ff;
   logic [17:0] sq;

   logic signed [23:0] y;
   logic [16:0] tbl_val;
   logic [15:0] lux_ff, lux_in;
   logic        fault_ff;

   logic signed [17:0] err_ff, err_in, prev_err_ff;
   logic signed [18:0] sum_in, lim_c, deriv_in, deriv_ff;
   logic signed [14:0] error_sum_ff, sum_ff;
   logic        clamped_ff, clamped_in;
   logic signed [35:0] acc_ff;
   logic [35:0] mag;
   logic signed [17:0] pid_ff, pid_in;
   logic signed [18:0] duty_base;
   logic [12:0] duty_ff, duty_in;
   logic        res_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plant_gain_ff     <= ldr_pkg::PLANT_GAIN_RST;
         prop_gain_ff      <= ldr_pkg::PROP_GAIN_RST;
         integ_gain_ff     <= ldr_pkg::INTEG_GAIN_RST;
         deriv_gain_ff     <= ldr_pkg::DERIV_GAIN_RST;
         integral_limit_ff <= ldr_pkg::INTEGRAL_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ldr_pkg::CSR_PLANT_GAIN:     plant_gain_ff <= csr_wr_data;
            ldr_pkg::CSR_PROP_GAIN:      prop_gain_ff <= csr_wr_data;
            ldr_pkg::CSR_INTEG_GAIN:     integ_gain_ff <= csr_wr_data;
            ldr_pkg::CSR_DERIV_GAIN:     deriv_gain_ff <= csr_wr_data;
            ldr_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_wr_data[13:0];
            default: begin
            end
         endcase
      end
   end

   // The window is sorted in place; every entry is rewritten before the next median.
   always_comb begin
      win_in = win_ff;
      if (cmd.sample_wr) begin
         win_in[count_ff] = adc_sample;
      end else if (cmd.sort_step) begin
         for (int i = 0; i < N - 1; i++) begin
            if (1'(i) == cmd.sort_odd && win_ff[i] > win_ff[i+1]) begin
               win_in[i]   = win_ff[i+1];
               win_in[i+1] = win_ff[i];
            end
         end
      end
   end

   assign median = win_ff[N/2];
   assign status.last_sample = (count_ff == ldr_pkg::WIN_IDX_W'(N - 1));

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.sample_wr) begin
         count_ff <= status.last_sample ? '0 : count_ff + 1'b1;
      end
      if (cmd.sample_wr) setpoint_ff <= setpoint_lux;
   end

   assign duty_base = $signed({7'd0, setpoint_ff}) + {pid_ff[17], pid_ff};

   always_comb begin
      unique case (cmd.mul_sel)
         ldr_pkg::MUL_VOLT: begin
            mul_a = $signed({10'd0, median});
            mul_b = $signed({6'd0, ldr_pkg::VOLT_SCALE});
         end
         ldr_pkg::MUL_SQ: begin
            mul_a = $signed({5'd0, m_ff});
            mul_b = $signed({1'b0, m_ff});
         end
         ldr_pkg::MUL_LOG: begin
            mul_a = $signed({1'b0, e_ff, frac_ff});
            mul_b = $signed({1'b0, ldr_pkg::LOG_SCALE});
         end
         ldr_pkg::MUL_P: begin
            mul_a = {{4{err_ff[17]}}, err_ff};
            mul_b = $signed({2'd0, prop_gain_ff});
         end
         ldr_pkg::MUL_I: begin
            mul_a = {{7{sum_ff[14]}}, sum_ff};
            mul_b = $signed({2'd0, integ_gain_ff});
         end
         ldr_pkg::MUL_D: begin
            mul_a = {{3{deriv_ff[18]}}, deriv_ff};
            mul_b = $signed({2'd0, deriv_gain_ff});
         end
         ldr_pkg::MUL_DUTY: begin
            mul_a = {{3{duty_base[18]}}, duty_base};
            mul_b = $signed({2'd0, plant_gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) prod_ff <= prod_in;

   assign status.volt_zero = (prod_ff[23:12] == 12'd0);
   assign status.res_small = (quo_ff <= ldr_pkg::R_OFFSET);
   assign status.norm_top  = norm_ff[24];

   assign div_t  = {rem_ff, dvd_ff[24]};
   assign div_ge = (div_t >= {1'b0, volt_ff});
   assign sq     = prod_ff[33:16];

   assign y       = ldr_pkg::Y_BASE - $signed({2'd0, prod_ff[37:16]});
   assign tbl_val = ldr_pkg::LUX_TABLE[y[15 -: ldr_pkg::LUX_IDX_W]];

   always_comb begin
      if (y < 0) lux_in = 16'd0;
      else if (y[23:20] != 4'd0) lux_in = 16'hFFFF;
      else lux_in = 16'(tbl_val >> (5'd16 - {1'b0, y[19:16]}));
   end

   always_ff @(posedge clock) begin
      if (cmd.volt_ld) begin
         volt_ff  <= prod_ff[23:12];
         rem_ff   <= '0;
         dvd_ff   <= ldr_pkg::DIV_DIVIDEND;
         quo_ff   <= '0;
         lux_ff   <= '0;
         fault_ff <= status.volt_zero;
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? 12'(div_t - {1'b0, volt_ff}) : div_t[11:0];
         dvd_ff <= {dvd_ff[23:0], 1'b0};
         quo_ff <= {quo_ff[23:0], div_ge};
      end
      if (cmd.res_ld) begin
         if (status.res_small) begin
            lux_ff   <= 16'hFFFF;
            fault_ff <= 1'b1;
         end
         norm_ff <= quo_ff - ldr_pkg::R_OFFSET;
         e_ff    <= ldr_pkg::NORM_TOP;
      end
      if (cmd.norm_step) begin
         if (norm_ff[24]) begin
            m_ff    <= norm_ff[24:8];
            frac_ff <= '0;
         end else begin
            norm_ff <= {norm_ff[23:0], 1'b0};
            e_ff    <= e_ff - 1'b1;
         end
      end
      if (cmd.sq_upd) begin
         m_ff    <= sq[17] ? sq[17:1] : sq[16:0];
         frac_ff <= {frac_ff[14:0], sq[17]};
      end
      if (cmd.lux_ld) lux_ff <= lux_in;
   end

   always_comb begin
      err_in   = $signed({6'd0, setpoint_ff}) - $signed({2'd0, lux_ff});
      sum_in   = {{4{error_sum_ff[14]}}, error_sum_ff} + {err_in[17], err_in};
      lim_c    = $signed({5'd0, integral_limit_ff});
      deriv_in = {err_in[17], err_in} - {prev_err_ff[17], prev_err_ff};
      clamped_in = 1'b0;
      if (sum_in > lim_c) begin
         sum_in     = lim_c;
         clamped_in = 1'b1;
      end else if (sum_in < -lim_c) begin
         sum_in     = -lim_c;
         clamped_in = 1'b1;
      end
   end

   always_comb begin
      mag = acc_ff[35] ? 36'(-acc_ff) : 36'(acc_ff);
      mag = mag >> 16;
      if (!acc_ff[35]) pid_in = (mag > 36'd131071) ? 18'sd131071 : $signed(mag[17:0]);
      else pid_in = (mag > 36'd131072) ? -18'sd131072 : $signed(18'(-mag[17:0]));
      if (prod_ff <= 0) duty_in = '0;
      else if (prod_ff[38:8] > 31'(ldr_pkg::PWM_RANGE)) duty_in = 13'(ldr_pkg::PWM_RANGE);
      else duty_in = prod_ff[20:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else if (cmd.err_ld) begin
         error_sum_ff <= 15'(sum_in);
         prev_err_ff  <= err_in;
      end
      if (cmd.err_ld) begin
         err_ff     <= err_in;
         sum_ff     <= 15'(sum_in);
         deriv_ff   <= deriv_in;
         clamped_ff <= clamped_in;
      end
      if (cmd.acc_clr) acc_ff <= '0;
      else if (cmd.acc_add) acc_ff <= acc_ff + prod_ff[35:0];
      if (cmd.pid_ld) pid_ff <= pid_in;
      if (cmd.duty_ld) duty_ff <= duty_in;
   end

   assign status.out_busy = res_valid_ff && !rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         res_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         res_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp.pwm_duty         <= duty_ff;
         rsp.measured_lux     <= lux_ff;
         rsp.control_error    <= err_ff[16:0];
         rsp.pid_output       <= pid_ff;
         rsp.integral_clamped <= clamped_ff;
         rsp.sensor_fault     <= fault_ff;
      end
   end

   assign rsp.valid = res_valid_ff;

   mant_normal: assert property (@(posedge clock) disable iff (reset)
      cmd.sq_upd |=> m_ff[16])
      else $error("log mantissa left its range");
   rem_below: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < volt_ff)
      else $error("divider remainder not below divisor");
   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!res_valid_ff || rsp.ready))
      else $error("result overwritten before taken");

endmodule

/* tb/ldr_light_pid_controller_top_test.sv */
module ldr_light_pid_controller_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD_CYCLES = 600;

   typedef struct {
      logic [12:0] pwm_duty;
      logic [15:0] measured_lux;
      logic [16:0] control_error;
      logic [17:0] pid_output;
      logic        integral_clamped;
      logic        sensor_fault;
   } ctrl_result_type;

   typedef struct {
      logic [11:0]     adc;
      logic [11:0]     setpoint;
      bit              typed;
      ctrl_result_type result;
   } sample_row_type;

   logic clock;
   logic reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wr_data;

   ldr_req_if req_chan ();
   ldr_rsp_if rsp_chan ();

   ldr_light_pid_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   ctrl_result_type pending_results[$];
   int unsigned  mismatch_count;
   int unsigned  lux_entry[ldr_pkg::LUX_TABLE_DEPTH];
   bit           gaps_on;
   bit           long_hold_req;

   int unsigned gain_plant, gain_prop, gain_integ, gain_deriv, sum_limit;
   int unsigned window_buf[ldr_pkg::MEDIAN_WINDOW];
   int unsigned window_fill;
   int          err_accum;
   int          last_err;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int unsigned frac_of_log2(longint unsigned m);
      int unsigned y;
      y = 0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 16;
         if (m >= 64'd131072) begin
            m = m >> 1;
            y |= 32'd1 << (15 - k);
         end
      end
      return y;
   endfunction

   function automatic int unsigned lux_from_ohms(int unsigned r);
      int e;
      longint unsigned mant;
      longint l2, y;
      int unsigned n, idx, v;
      e = 31;
      while (e > 0 && r[e] == 1'b0) e--;
      if (e >= 16) mant = 64'(r >> (e - 16));
      else mant = 64'(r) << (16 - e);
      l2 = longint'(e) * 65536 + longint'(frac_of_log2(mant));
      y = 64'sd1339366 - longint'((64'd120722 * 64'(l2)) >> 16);
      if (y < 0) return 0;
      if (y >= 16 * 65536) return 65535;
      n = 32'(y >> 16);
      idx = 32'(((y & 64'hFFFF) * ldr_pkg::LUX_TABLE_DEPTH) >> 16);
      if (idx >= ldr_pkg::LUX_TABLE_DEPTH) idx = ldr_pkg::LUX_TABLE_DEPTH - 1;
      v = lux_entry[idx[ldr_pkg::LUX_IDX_W-1:0]] >> (16 - n);
      return (v > 65535) ? 65535 : v;
   endfunction

   task automatic predict_control_step(input logic [11:0] adc, input logic [11:0] setpoint);
      int unsigned sorted[$];
      int unsigned med, volt, q, lux;
      bit fault, clamped;
      int err, sum, lim, deriv, pid;
      longint s, mag, duty;
      ctrl_result_type r;
      if (window_fill >= ldr_pkg::MEDIAN_WINDOW) window_fill = 0;
      window_buf[window_fill] = {20'd0, adc};
      window_fill++;
      if (window_fill < ldr_pkg::MEDIAN_WINDOW) return;
      window_fill = 0;
      for (int a = 0; a < ldr_pkg::MEDIAN_WINDOW; a++) sorted.push_back(window_buf[a]);
      sorted.sort();
      med = sorted[ldr_pkg::MEDIAN_WINDOW / 2];
      fault = 1'b0;
      clamped = 1'b0;
      volt = med * 3300 / 4096;
      if (volt == 0) begin
         lux = 0;
         fault = 1'b1;
      end else begin
         q = 33000000 / volt;
         if (q <= 10000) begin
            lux = 65535;
            fault = 1'b1;
         end else begin
            lux = lux_from_ohms(q - 10000);
         end
      end
      err = int'({20'd0, setpoint}) - int'(lux);
      lim = int'(sum_limit);
      sum = err_accum + err;
      if (sum > lim) begin
         sum = lim;
         clamped = 1'b1;
      end else if (sum < -lim) begin
         sum = -lim;
         clamped = 1'b1;
      end
      err_accum = sum;
      deriv = err - last_err;
      last_err = err;
      s = longint'(gain_prop) * err + longint'(gain_integ) * sum
          + longint'(gain_deriv) * deriv;
      mag = (s < 0) ? -s : s;
      mag = mag >>> 16;
      s = (s < 0) ? -mag : mag;
      if (s > 131071) s = 131071;
      if (s < -131072) s = -131072;
      pid = int'(s);
      duty = (longint'({20'd0, setpoint}) + pid) * longint'(gain_plant);
      if (duty <= 0) duty = 0;
      else begin
         duty = duty >>> 8;
         if (duty > ldr_pkg::PWM_RANGE) duty = ldr_pkg::PWM_RANGE;
      end
      r.pwm_duty = duty[12:0];
      r.measured_lux = lux[15:0];
      r.control_error = err[16:0];
      r.pid_output = pid[17:0];
      r.integral_clamped = clamped;
      r.sensor_fault = fault;
      pending_results.push_back(r);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         ldr_pkg::CSR_PLANT_GAIN:     gain_plant = {16'd0, value};
         ldr_pkg::CSR_PROP_GAIN:      gain_prop = {16'd0, value};
         ldr_pkg::CSR_INTEG_GAIN:     gain_integ = {16'd0, value};
         ldr_pkg::CSR_DERIV_GAIN:     gain_deriv = {16'd0, value};
         ldr_pkg::CSR_INTEGRAL_LIMIT: sum_limit = {18'd0, value[13:0]};
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_gains(input logic [15:0] plant, input logic [15:0] prop,
                                  input logic [15:0] integ, input logic [15:0] deriv,
                                  input logic [15:0] limit);
      write_register(ldr_pkg::CSR_PLANT_GAIN, plant);
      write_register(ldr_pkg::CSR_PROP_GAIN, prop);
      write_register(ldr_pkg::CSR_INTEG_GAIN, integ);
      write_register(ldr_pkg::CSR_DERIV_GAIN, deriv);
      write_register(ldr_pkg::CSR_INTEGRAL_LIMIT, limit);
      write_register(CSR_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
   endtask

   task automatic send_sample(input sample_row_type row);
      int gap;
      gap = gaps_on ? int'($urandom_range(0, 6)) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.adc_sample <= row.adc;
      req_chan.setpoint_lux <= row.setpoint;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_control_step(row.adc, row.setpoint);
      if (row.typed) begin
         void'(pending_results.pop_back());
         pending_results.push_back(row.result);
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [11:0] random_adc(int unsigned style);
      case (style)
         0: return 12'($urandom_range(0, 4095));
         1: return 12'($urandom_range(0, 12));
         2: return 12'($urandom_range(3900, 4095));
         default: return 12'($urandom_range(200, 1200));
      endcase
   endfunction

   task automatic send_random_windows(input int unsigned windows);
      sample_row_type row;
      int unsigned style;
      logic [11:0] setpoint;
      for (int w = 0; w < windows; w++) begin
         style = $urandom_range(0, 3);
         setpoint = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'($urandom_range(0, 800));
         if (w % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < ldr_pkg::MEDIAN_WINDOW; k++) begin
            row.adc = random_adc((k == 2 && $urandom_range(0, 1) != 0) ? 0 : style);
            row.setpoint = setpoint;
            row.typed = 1'b0;
            send_sample(row);
         end
      end
   endtask

   always begin
      int stall;
      stall = gaps_on ? int'($urandom_range(0, 6)) : 0;
      if (stall > 0) begin
         rsp_chan.ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      if (long_hold_req) begin
         rsp_chan.ready <= 1'b0;
         repeat (LONG_HOLD_CYCLES) @(posedge clock);
         long_hold_req = 1'b0;
      end
      rsp_chan.ready <= 1'b1;
      do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && reset === 1'b0));
      if (pending_results.size() == 0) begin
         $error("result arrived with none expected");
         mismatch_count++;
      end else begin
         ctrl_result_type e;
         e = pending_results.pop_front();
         if (rsp_chan.pwm_duty !== e.pwm_duty) begin
            $error("pwm_duty expected %0d got %0d", e.pwm_duty, rsp_chan.pwm_duty);
            mismatch_count++;
         end
         if (rsp_chan.measured_lux !== e.measured_lux) begin
            $error("measured_lux expected %0d got %0d", e.measured_lux,
                   rsp_chan.measured_lux);
            mismatch_count++;
         end
         if (rsp_chan.control_error !== e.control_error) begin
            $error("control_error expected %0d got %0d", $signed(e.control_error),
                   rsp_chan.control_error);
            mismatch_count++;
         end
         if (rsp_chan.pid_output !== e.pid_output) begin
            $error("pid_output expected %0d got %0d", $signed(e.pid_output),
                   rsp_chan.pid_output);
            mismatch_count++;
         end
         if (rsp_chan.integral_clamped !== e.integral_clamped) begin
            $error("integral_clamped expected %0b got %0b", e.integral_clamped,
                   rsp_chan.integral_clamped);
            mismatch_count++;
         end
         if (rsp_chan.sensor_fault !== e.sensor_fault) begin
            $error("sensor_fault expected %0b got %0b", e.sensor_fault,
                   rsp_chan.sensor_fault);
            mismatch_count++;
         end
      end
   end

   initial begin
      sample_row_type directed[$];
      ctrl_result_type fault_dark;
      logic [11:0] mixed[5];

      mismatch_count = 0;
      gaps_on = 1'b1;
      long_hold_req = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= ldr_pkg::CSR_PLANT_GAIN;
      csr_wr_data <= '0;
      req_chan.valid <= 1'b0;
      req_chan.adc_sample <= '0;
      req_chan.setpoint_lux <= '0;

      for (int i = 0; i < ldr_pkg::LUX_TABLE_DEPTH; i++) begin
         int unsigned t, lo, hi, mid;
         t = (i * 65536) / ldr_pkg::LUX_TABLE_DEPTH;
         lo = 65536;
         hi = 131071;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (frac_of_log2(64'(mid)) <= t) lo = mid;
            else hi = mid - 1;
         end
         lux_entry[i] = lo;
      end
      gain_plant = {16'd0, ldr_pkg::PLANT_GAIN_RST};
      gain_prop = {16'd0, ldr_pkg::PROP_GAIN_RST};
      gain_integ = {16'd0, ldr_pkg::INTEG_GAIN_RST};
      gain_deriv = {16'd0, ldr_pkg::DERIV_GAIN_RST};
      sum_limit = {18'd0, ldr_pkg::INTEGRAL_LIMIT_RST};
      window_fill = 0;
      err_accum = 0;
      last_err = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A dark window right after reset reads zero volts and flags the sensor.
      fault_dark = '{13'd0, 16'd0, 17'd0, 18'd0, 1'b0, 1'b1};
      for (int k = 0; k < 5; k++)
         directed.push_back('{12'd0, 12'd0, k == 4, fault_dark});
      for (int k = 0; k < 5; k++)
         directed.push_back('{12'd4095, 12'd4095, 1'b0, fault_dark});
      mixed = '{12'd4095, 12'd0, 12'd2048, 12'd1, 12'd4094};
      for (int k = 0; k < 5; k++)
         directed.push_back('{mixed[k], 12'd2000, 1'b0, fault_dark});
      for (int k = 0; k < 5; k++)
         directed.push_back('{12'd1, 12'd4095, 1'b0, fault_dark});
      mixed = '{12'd700, 12'd2730, 12'd1365, 12'd3000, 12'd500};
      for (int k = 0; k < 5; k++)
         directed.push_back('{mixed[k], 12'd0, 1'b0, fault_dark});
      foreach (directed[i]) send_sample(directed[i]);
      drain_results();

      write_all_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_random_windows(40);
      drain_results();

      write_all_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3FFF);
      long_hold_req = 1'b1;
      send_random_windows(70);
      drain_results();

      write_all_gains(ldr_pkg::PLANT_GAIN_RST, ldr_pkg::PROP_GAIN_RST,
                      ldr_pkg::INTEG_GAIN_RST, ldr_pkg::DERIV_GAIN_RST,
                      {2'd0, ldr_pkg::INTEGRAL_LIMIT_RST});
      send_random_windows(90);
      drain_results();

      write_all_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 16383)));
      long_hold_req = 1'b1;
      send_random_windows(70);
      drain_results();

      write_all_gains(16'($urandom_range(128, 1024)), 16'($urandom_range(0, 4000)),
                      16'($urandom_range(0, 30000)), 16'($urandom_range(0, 4000)),
                      16'($urandom_range(0, 200)));
      send_random_windows(70);
      drain_results();

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/ldr_pkg.sv
hw/rtl/ldr_if.sv
hw/rtl/ldr_ctrl.sv
hw/rtl/ldr_datapath.sv
hw/rtl/ldr_light_pid_controller_top.sv
tb/ldr_light_pid_controller_top_test.sv
